@@ src/vsb_pkg.sv @@
// ----------------------------------------------------------------------------
// vsb_pkg
// Shared types and constants for the VWAP standard deviation band block.
// ----------------------------------------------------------------------------
package vsb_pkg;

  localparam int PRICE_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic        day_start;
    logic [31:0] bar_high;
    logic [31:0] bar_low;
    logic [31:0] bar_close;
    logic [31:0] bar_volume;
  } bar_t;

  typedef struct packed {
    logic [31:0] vwap_price;
    logic [31:0] upper_one;
    logic [31:0] upper_two;
    logic [31:0] lower_one;
    logic [31:0] lower_two;
    logic        sum_overflow;
  } result_t;

  // Clear-only items carry a day start with no volume.
  typedef enum logic {
    OP_CLEAR  = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  typedef struct packed {
    logic        day_start;
    op_t         op;
    logic [33:0] price_sum;
    logic [31:0] volume;
  } work_t;

  function automatic logic [31:0] price_max(int bits);
    logic [63:0] full;
    full = (64'd1 << bits) - 64'd1;
    return full[31:0];
  endfunction

endpackage

@@ src/vsb_front.sv @@
// ----------------------------------------------------------------------------
// vsb_front
// Accepts bars, clamps prices, forms h+l+c and classifies each bar.
// ----------------------------------------------------------------------------
module vsb_front #(
  parameter int PRICE_BITS = vsb_pkg::PRICE_BITS_DEF
) (
  input  logic            push,
  output logic            full,
  input  vsb_pkg::bar_t   bar,
  input  logic            q_full,
  output logic            q_push,
  output vsb_pkg::work_t  q_data
);
  import vsb_pkg::*;

  localparam logic [31:0] PMAX = price_max(PRICE_BITS);

  logic [31:0] h, l, c;
  logic        accepted;

  assign full     = q_full;
  assign accepted = push && !q_full;

  always_comb begin
    h = (bar.bar_high  > PMAX) ? PMAX : bar.bar_high;
    l = (bar.bar_low   > PMAX) ? PMAX : bar.bar_low;
    c = (bar.bar_close > PMAX) ? PMAX : bar.bar_close;
    q_data.day_start = bar.day_start;
    q_data.op        = (bar.bar_volume != 32'd0) ? OP_UPDATE : OP_CLEAR;
    q_data.price_sum = {2'b00, h} + {2'b00, l} + {2'b00, c};
    q_data.volume    = bar.bar_volume;
  end

  // Drop bars that neither clear nor update.
  assign q_push = accepted && (bar.day_start || (bar.bar_volume != 32'd0));

endmodule

@@ src/vsb_queue.sv @@
// ----------------------------------------------------------------------------
// vsb_queue
// Short FIFO of classified work between the front and the back.
// ----------------------------------------------------------------------------
module vsb_queue #(
  parameter int DEPTH = vsb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  vsb_pkg::work_t wr_data,
  output logic           full,
  input  logic           rd,
  output vsb_pkg::work_t rd_data,
  output logic           empty
);
  import vsb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  work_t         mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(wr && !full) - CW'(rd && !empty);
    end
  end

endmodule

@@ src/vsb_back.sv @@
// ----------------------------------------------------------------------------
// vsb_back
// Sequencer holding the running sums; shared restoring divider, bitwise
// square root and 32x32 multiplications; registered result.
// ----------------------------------------------------------------------------
module vsb_back #(
  parameter int PRICE_BITS = vsb_pkg::PRICE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  vsb_pkg::work_t    q_data,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output vsb_pkg::result_t  result
);
  import vsb_pkg::*;

  localparam logic [31:0] PMAX    = price_max(PRICE_BITS);
  localparam logic [31:0] RECIP3  = 32'hAAAA_AAAB;
  localparam logic [31:0] THIRD32 = 32'h5555_5555;

  typedef enum logic [15:0] {
    S_IDLE   = 16'b0000000000000001,
    S_DIV3   = 16'b0000000000000010,
    S_MUL_PV = 16'b0000000000000100,
    S_MUL_TT = 16'b0000000000001000,
    S_MUL_LO = 16'b0000000000010000,
    S_MUL_HI = 16'b0000000000100000,
    S_COMB   = 16'b0000000001000000,
    S_ACC_P  = 16'b0000000010000000,
    S_ACC_S  = 16'b0000000100000000,
    S_DIVV   = 16'b0000001000000000,
    S_DIVS   = 16'b0000010000000000,
    S_VSQ    = 16'b0000100000000000,
    S_VAR    = 16'b0001000000000000,
    S_SQRT   = 16'b0010000000000000,
    S_BANDS  = 16'b0100000000000000,
    S_TP3    = 16'b1000000000000000
  } state_t;

  function automatic logic [128:0] add_sat(logic [127:0] a, logic [127:0] b);
    logic [128:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[128]) begin
      s = {1'b1, {128{1'b1}}};
    end
    return s;
  endfunction

  state_t        st;
  logic [6:0]    cnt;
  logic [31:0]   tp, vol, vwap;
  logic [63:0]   vsum, pv_term, tp2, term_lo, term_hi, prod;
  logic [95:0]   sq_term;
  logic [127:0]  pvsum, sqsum, msq, var_q;
  logic          ovf;
  logic [127:0]  div_n, div_q;
  logic [63:0]   div_r, div_d;
  logic [127:0]  sq_n;
  logic [65:0]   rem;
  logic [63:0]   root;
  logic          out_valid;

  // typical price by reciprocal multiplication
  logic [33:0]  psum;
  logic [63:0]  recip;
  logic [30:0]  q3;
  logic [31:0]  r3;
  logic [2:0]   fix3;
  logic [31:0]  base3;
  logic [31:0]  tp3;
  // divider step
  logic [64:0]  div_r2;
  logic         div_ge;
  logic [63:0]  div_r_next;
  logic [127:0] div_q_next;
  // root step
  logic [67:0]  rem2, trial;
  logic         sq_ge;
  logic [65:0]  rem_next;
  // accumulation
  logic [64:0]  vsum_add;
  logic [128:0] pv_add, sq_add;
  // bands
  logic         sd_over, take;
  logic [32:0]  sd1, sd2;
  logic [33:0]  up1, up2;

  always_comb begin
    // low word over three, then fold in the top two bits (2^32 = 3*THIRD32 + 1)
    q3    = recip[63:33];
    r3    = psum[31:0] - {q3, 1'b0} - {1'b0, q3};
    fix3  = {1'b0, psum[33:32]} + {1'b0, r3[1:0]};
    base3 = (psum[33:32] == 2'd2) ? {THIRD32[30:0], 1'b0} :
            (psum[33:32] == 2'd1) ? THIRD32 : 32'd0;
    tp3   = base3 + {1'b0, q3} + ((fix3 >= 3'd3) ? 32'd1 : 32'd0);

    div_r2     = {div_r, div_n[127]};
    div_ge     = div_r2 >= {1'b0, div_d};
    div_r_next = div_ge ? 64'(div_r2 - {1'b0, div_d}) : div_r2[63:0];
    div_q_next = {div_q[126:0], div_ge};

    rem2     = {rem, sq_n[127:126]};
    trial    = {2'b00, root, 2'b01};
    sq_ge    = rem2 >= trial;
    rem_next = sq_ge ? 66'(rem2 - trial) : rem2[65:0];

    vsum_add = {1'b0, vsum} + {33'b0, vol};
    pv_add   = add_sat(pvsum, {64'b0, pv_term});
    sq_add   = add_sat(sqsum, {32'b0, sq_term});

    sd_over = root > {32'b0, PMAX};
    sd1     = {1'b0, root[31:0]};
    sd2     = {root[31:0], 1'b0};
    up1     = {2'b00, vwap} + {1'b0, sd1};
    up2     = {2'b00, vwap} + {1'b0, sd2};
  end

  assign take  = !out_valid || pop;
  assign q_pop = (st == S_IDLE) && !q_empty;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == S_BANDS && take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      cnt       <= '0;
      vsum      <= '0;
      pvsum     <= '0;
      sqsum     <= '0;
      ovf       <= 1'b0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_data.day_start) begin
              vsum  <= '0;
              pvsum <= '0;
              sqsum <= '0;
              ovf   <= 1'b0;
            end
            if (q_data.op == OP_UPDATE) begin
              vol  <= q_data.volume;
              psum <= q_data.price_sum;
              st   <= S_DIV3;
            end
          end
        end
        S_DIV3: begin
          recip <= psum[31:0] * RECIP3;
          st    <= S_TP3;
        end
        S_TP3: begin
          tp <= tp3;
          st <= S_MUL_PV;
        end
        S_DIVV, S_DIVS: begin
          cnt <= cnt + 1'b1;
          if (cnt == 7'd127 && st == S_DIVV) begin
            vwap  <= (div_q_next[127:32] != '0 || div_q_next[31:0] > PMAX)
                     ? PMAX : div_q_next[31:0];
            div_n <= sqsum;
            div_r <= '0;
            div_q <= '0;
            st    <= S_DIVS;
          end else begin
            div_n <= {div_n[126:0], 1'b0};
            div_r <= div_r_next;
            div_q <= div_q_next;
            if (cnt == 7'd127) begin
              msq <= div_q_next;
              st  <= S_VSQ;
            end
          end
        end
        S_MUL_PV: begin
          pv_term <= tp * vol;
          st      <= S_MUL_TT;
        end
        S_MUL_TT: begin
          tp2 <= tp * tp;
          st  <= S_MUL_LO;
        end
        S_MUL_LO: begin
          term_lo <= tp2[31:0] * vol;
          st      <= S_MUL_HI;
        end
        S_MUL_HI: begin
          term_hi <= tp2[63:32] * vol;
          st      <= S_COMB;
        end
        S_COMB: begin
          sq_term <= {32'b0, term_lo} + {term_hi, 32'b0};
          if (vsum_add[64]) begin
            vsum <= '1;
            ovf  <= 1'b1;
          end else begin
            vsum <= vsum_add[63:0];
          end
          st <= S_ACC_P;
        end
        S_ACC_P: begin
          pvsum <= pv_add[127:0];
          if (pv_add[128]) begin
            ovf <= 1'b1;
          end
          st <= S_ACC_S;
        end
        S_ACC_S: begin
          sqsum <= sq_add[127:0];
          if (sq_add[128]) begin
            ovf <= 1'b1;
          end
          div_n <= pvsum;
          div_d <= vsum;
          div_r <= '0;
          div_q <= '0;
          cnt   <= '0;
          st    <= S_DIVV;
        end
        S_VSQ: begin
          prod <= vwap * vwap;
          st   <= S_VAR;
        end
        S_VAR: begin
          var_q <= (msq > {64'b0, prod}) ? msq - {64'b0, prod} : '0;
          sq_n  <= (msq > {64'b0, prod}) ? msq - {64'b0, prod} : '0;
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          st    <= S_SQRT;
        end
        S_SQRT: begin
          rem  <= rem_next;
          root <= {root[62:0], sq_ge};
          sq_n <= {sq_n[125:0], 2'b00};
          cnt  <= cnt + 1'b1;
          if (cnt == 7'd63) begin
            st <= S_BANDS;
          end
        end
        S_BANDS: begin
          // hold until the result register frees up
          if (take) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_BANDS && take) begin
      result.vwap_price   <= vwap;
      result.sum_overflow <= ovf;
      if (var_q == '0 || !sd_over) begin
        result.upper_one <= (up1 > {2'b00, PMAX}) ? PMAX : up1[31:0];
        result.upper_two <= (up2 > {2'b00, PMAX}) ? PMAX : up2[31:0];
        result.lower_one <= ({1'b0, vwap} > sd1) ? 32'({1'b0, vwap} - sd1) : '0;
        result.lower_two <= ({1'b0, vwap} > sd2) ? 32'({1'b0, vwap} - sd2) : '0;
      end else begin
        result.upper_one <= PMAX;
        result.upper_two <= PMAX;
        result.lower_one <= '0;
        result.lower_two <= '0;
      end
    end
  end

endmodule

@@ src/vwap_stddev_bands_top.sv @@
// ----------------------------------------------------------------------------
// vwap_stddev_bands_top
// VWAP with one and two standard deviation bands over daily running sums.
// ----------------------------------------------------------------------------
// Bars enter through a small work queue and are processed one at a time by
// a sequencer; it takes a new bar only when it is through with the last
// one, and an unread result on the output holds it. Each bar with volume goes
// through two passes of the shared 128-step restoring divider
// (price-volume sum and square-volume sum by the volume sum) and the 64-step
// square root; the typical price uses a reciprocal multiplication by one
// third. A day-start bar with zero volume only clears the sums and gives no
// result; a zero-volume bar without day start is dropped. Up to QUEUE_DEPTH
// bars can wait in the queue plus one in the sequencer behind an unread result.
module vwap_stddev_bands_top #(
  parameter int PRICE_BITS  = vsb_pkg::PRICE_BITS_DEF,
  parameter int QUEUE_DEPTH = vsb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  vsb_pkg::bar_t     bar,
  output logic              empty,
  input  logic              pop,
  output vsb_pkg::result_t  result
);
  import vsb_pkg::*;

  logic  q_push, q_full, q_pop, q_empty;
  work_t q_wdata, q_rdata;

  vsb_front #(.PRICE_BITS(PRICE_BITS)) u_front (
    .push   (push),
    .full   (full),
    .bar    (bar),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  vsb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  vsb_back #(.PRICE_BITS(PRICE_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

@@ src/vsb_checker.sv @@
// ----------------------------------------------------------------------------
// vsb_checker
// Port-level checks on the VWAP band block, bound to the top level.
// ----------------------------------------------------------------------------
module vsb_checker (
  input logic             clk,
  input logic             rst,
  input logic             push,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input vsb_pkg::result_t result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

  a_order_low: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.lower_two <= result.lower_one &&
               result.lower_one <= result.vwap_price)
    else $error("lower bands out of order");

  a_order_high: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.vwap_price <= result.upper_one &&
               result.upper_one <= result.upper_two)
    else $error("upper bands out of order");

endmodule

bind vwap_stddev_bands_top vsb_checker u_chk (.*);
